/* sv/fes_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fes_pkg;

  localparam int SymW = 8;
  localparam int EscLen = 8;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  localparam logic [SymW-1:0] ESC_BODY = 8'h31;
  localparam logic [SymW-1:0] ESC_TAIL = 8'h30;

  localparam logic [3:0] FLAG_LEN_MIN = 4'd1;
  localparam logic [3:0] FLAG_LEN_MAX = 4'd8;
  localparam logic [3:0] FLAG_LEN_RESET = 4'd8;
  localparam logic [63:0] FLAG_PATTERN_RESET = 64'h3031_3131_3131_3130;

  localparam logic REG_FLAG_LEN = 1'b0;
  localparam logic REG_FLAG_PATTERN = 1'b1;

  typedef struct packed {
    logic ins;
    logic clear;
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic            esc;
    logic            head;
    logic [SymW-1:0] head_sym;
    logic            flag;
    logic            closing;
  } job_t;

endpackage

`default_nettype wire

/* sv/fes_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module fes_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  fes_pkg::cell_ctrl_t    ctrl,
  input  logic [7:0]             sym_in,
  input  logic                   prev_valid,
  input  logic [7:0]             next_sym,
  input  logic                   next_valid,
  input  logic                   flag_use,
  input  logic [7:0]             flag_sym,
  input  logic                   esc_use,
  input  logic [7:0]             esc_sym,
  input  logic                   flag_chain_in,
  input  logic                   esc_chain_in,
  output logic [7:0]             cur_sym,
  output logic                   cur_valid,
  output logic                   held_valid,
  output logic                   flag_chain_out,
  output logic                   esc_chain_out
);

  logic [7:0] sym;
  logic       valid;
  logic       insert_here;

  assign insert_here = ctrl.ins && !valid && prev_valid;
  assign cur_sym     = insert_here ? sym_in : sym;
  assign cur_valid   = valid || insert_here;
  assign held_valid  = valid;

  assign flag_chain_out = flag_chain_in &&
                          (!flag_use || (cur_valid && (cur_sym == flag_sym)));
  assign esc_chain_out  = esc_chain_in &&
                          (!esc_use || (cur_valid && (cur_sym == esc_sym)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (ctrl.load) begin
      valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      sym <= next_sym;
    end else if (ctrl.load) begin
      sym <= cur_sym;
    end
  end

endmodule

`default_nettype wire

/* sv/fes_emitter.sv */
`timescale 1ns / 1ps
`default_nettype none

module fes_emitter (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_load,
  input  fes_pkg::job_t    job,
  input  logic [3:0]       flag_n,
  input  logic [63:0]      flag_pattern,
  output logic             busy_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       symbol_out,
  output logic             run_last,
  output logic             frame_end
);

  logic [3:0] esc_left;
  logic       head_vld;
  logic [7:0] head_sym;
  logic [3:0] flag_left;
  logic [2:0] flag_idx;
  logic       closing;

  logic [4:0] remaining;
  logic       room;
  logic       emit;
  logic [7:0] sym_next;
  logic       end_next;

  assign remaining  = 5'(esc_left) + 5'(head_vld) + 5'(flag_left);
  assign room       = !out_valid || !out_stall;
  assign emit       = (remaining != 5'd0) && room;
  assign busy_stall = (remaining != 5'd0) && !((remaining == 5'd1) && room);

  always_comb begin
    end_next = 1'b0;
    if (esc_left != 4'd0) begin
      sym_next = (esc_left == 4'd1) ? fes_pkg::ESC_TAIL : fes_pkg::ESC_BODY;
    end else if (head_vld) begin
      sym_next = head_sym;
    end else begin
      sym_next = flag_pattern[8*flag_idx +: 8];
      end_next = closing && (flag_left == 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_left  <= 4'd0;
      head_vld  <= 1'b0;
      flag_left <= 4'd0;
    end else if (job_load) begin
      esc_left  <= job.esc ? 4'(fes_pkg::EscLen) : 4'd0;
      head_vld  <= job.head;
      flag_left <= job.flag ? flag_n : 4'd0;
    end else if (emit) begin
      if (esc_left != 4'd0) begin
        esc_left <= esc_left - 4'd1;
      end else if (head_vld) begin
        head_vld <= 1'b0;
      end else begin
        flag_left <= flag_left - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      head_sym <= job.head_sym;
      closing  <= job.closing;
      flag_idx <= 3'd0;
    end else if (emit && (esc_left == 4'd0) && !head_vld) begin
      flag_idx <= flag_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      symbol_out <= sym_next;
      run_last   <= (remaining == 5'd1);
      frame_end  <= end_next;
    end
  end

endmodule

`default_nettype wire

/* sv/flag_escape_stuffer.sv */
// Each input word, when taken, loads a job into the emitter; its results leave through the
// output register. Throughput: one input word per cycle while each word causes at most one
// result and the output is free; more results stall the input, emitted one per cycle when free.
// Reset (rst, synchronous, active high) empties the lookahead window, clears the pass count,
// drops pending results and the output register, and restores both configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module flag_escape_stuffer #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  symbol_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  symbol_out,
  output logic        run_last,
  output logic        frame_end
);

  logic [3:0]  flag_len;
  logic [63:0] flag_pattern;
  logic [3:0]  flag_n;
  logic [2:0]  pass_left;

  logic        accept;
  logic        op_start;
  logic        op_data;
  logic        op_drain;
  logic        process;
  logic        closing;
  logic        flag_match;
  logic        esc_match;

  fes_pkg::cell_ctrl_t ctrl;
  fes_pkg::job_t       job;

  logic [7:0] cell_sym   [WINDOW_DEPTH];
  logic       cell_valid [WINDOW_DEPTH];
  logic       cell_held  [WINDOW_DEPTH];
  logic       flag_chain [WINDOW_DEPTH+1];
  logic       esc_chain  [WINDOW_DEPTH+1];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_len     <= fes_pkg::FLAG_LEN_RESET;
      flag_pattern <= fes_pkg::FLAG_PATTERN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3])
        fes_pkg::REG_FLAG_LEN:     flag_len <= pwdata[3:0];
        fes_pkg::REG_FLAG_PATTERN: flag_pattern <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      fes_pkg::REG_FLAG_LEN:     prdata = {60'd0, flag_len};
      fes_pkg::REG_FLAG_PATTERN: prdata = flag_pattern;
      default:                   prdata = 64'd0;
    endcase
  end

  always_comb begin
    if (flag_len == 4'd0) begin
      flag_n = fes_pkg::FLAG_LEN_MIN;
    end else if (flag_len > fes_pkg::FLAG_LEN_MAX) begin
      flag_n = fes_pkg::FLAG_LEN_MAX;
    end else begin
      flag_n = flag_len;
    end
  end

  assign accept   = in_valid && !in_stall;
  assign op_start = (opcode == fes_pkg::OP_START);
  assign op_data  = (opcode == fes_pkg::OP_DATA);
  assign op_drain = (opcode == fes_pkg::OP_DRAIN);

  assign process = (op_data && cell_valid[WINDOW_DEPTH-1]) || (op_drain && cell_valid[0]);
  assign closing = op_drain && !cell_valid[1];

  assign ctrl.ins   = op_data;
  assign ctrl.clear = accept && op_start;
  assign ctrl.shift = accept && process;
  assign ctrl.load  = accept && op_data;

  assign flag_chain[WINDOW_DEPTH] = 1'b1;
  assign esc_chain[WINDOW_DEPTH]  = 1'b1;
  assign flag_match = flag_chain[0];
  assign esc_match  = esc_chain[0];

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    logic       prev_valid;
    logic [7:0] next_sym;
    logic       next_valid;
    logic       flag_use;
    logic [7:0] flag_sym;
    logic       esc_use;
    logic [7:0] esc_sym;

    if (k == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cell_held[k-1];
    end

    if (k == WINDOW_DEPTH - 1) begin : g_tail
      assign next_sym   = 8'h00;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_sym   = cell_sym[k+1];
      assign next_valid = cell_valid[k+1];
    end

    if (k < fes_pkg::EscLen) begin : g_pat
      assign flag_use = (4'(k) < flag_n);
      assign flag_sym = flag_pattern[8*k +: 8];
      assign esc_use  = 1'b1;
      assign esc_sym  = (k == fes_pkg::EscLen - 1) ? fes_pkg::ESC_TAIL : fes_pkg::ESC_BODY;
    end else begin : g_nopat
      assign flag_use = 1'b0;
      assign flag_sym = 8'h00;
      assign esc_use  = 1'b0;
      assign esc_sym  = 8'h00;
    end

    fes_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .sym_in         (symbol_in),
      .prev_valid     (prev_valid),
      .next_sym       (next_sym),
      .next_valid     (next_valid),
      .flag_use       (flag_use),
      .flag_sym       (flag_sym),
      .esc_use        (esc_use),
      .esc_sym        (esc_sym),
      .flag_chain_in  (flag_chain[k+1]),
      .esc_chain_in   (esc_chain[k+1]),
      .cur_sym        (cell_sym[k]),
      .cur_valid      (cell_valid[k]),
      .held_valid     (cell_held[k]),
      .flag_chain_out (flag_chain[k]),
      .esc_chain_out  (esc_chain[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_left <= 3'd0;
    end else if (accept) begin
      if (op_start || closing) begin
        pass_left <= 3'd0;
      end else if (process) begin
        if (pass_left != 3'd0) begin
          pass_left <= pass_left - 3'd1;
        end else if (flag_match) begin
          pass_left <= 3'(flag_n - 4'd1);
        end else if (esc_match) begin
          pass_left <= 3'(fes_pkg::EscLen - 1);
        end
      end
    end
  end

  assign job.esc      = process && (pass_left == 3'd0) && (flag_match || esc_match);
  assign job.head     = process;
  assign job.head_sym = cell_sym[0];
  assign job.flag     = op_start || closing;
  assign job.closing  = closing;

  fes_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .job_load     (accept),
    .job          (job),
    .flag_n       (flag_n),
    .flag_pattern (flag_pattern),
    .busy_stall   (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol_out   (symbol_out),
    .run_last     (run_last),
    .frame_end    (frame_end)
  );

endmodule

`default_nettype wire

/* tb/flag_escape_stuffer_checker.sv */
`timescale 1ns / 1ps

module flag_escape_stuffer_checker #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  symbol_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  symbol_out,
  input  logic        run_last,
  input  logic        frame_end,
  output int          fails,
  output int          pending
);

  localparam logic [3:0] ADDR_FLAG_LEN = {fes_pkg::REG_FLAG_LEN, 3'b000};
  localparam logic [3:0] ADDR_FLAG_PATTERN = {fes_pkg::REG_FLAG_PATTERN, 3'b000};

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
    logic       fend;
  } framed_word_t;

  logic [3:0]  flag_len;
  logic [63:0] flag_pat;
  logic [7:0]  window [WINDOW_DEPTH];
  int          held;
  int          pass_left;
  framed_word_t stuffed_q[$];
  framed_word_t word_q[$];

  function automatic int flag_span();
    if (flag_len < fes_pkg::FLAG_LEN_MIN) return int'(fes_pkg::FLAG_LEN_MIN);
    if (flag_len > fes_pkg::FLAG_LEN_MAX) return int'(fes_pkg::FLAG_LEN_MAX);
    return int'(flag_len);
  endfunction

  function automatic logic [7:0] esc_sym(input int k);
    return (k == fes_pkg::EscLen - 1) ? fes_pkg::ESC_TAIL : fes_pkg::ESC_BODY;
  endfunction

  function automatic logic flag_at_head();
    int n;
    n = flag_span();
    if (held < n) return 1'b0;
    for (int k = 0; k < n; k++) begin
      if (window[k] != flag_pat[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic escape_at_head();
    if (held < fes_pkg::EscLen) return 1'b0;
    for (int k = 0; k < fes_pkg::EscLen; k++) begin
      if (window[k] != esc_sym(k)) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_window();
    for (int k = 0; k < WINDOW_DEPTH; k++) window[k] = 8'h00;
    held = 0;
    pass_left = 0;
  endtask

  task automatic put_sym(input logic [7:0] s, input logic e);
    framed_word_t w;
    w.sym = s;
    w.last = 1'b0;
    w.fend = e;
    word_q.push_back(w);
  endtask

  task automatic put_flag(input logic closing);
    int n;
    n = flag_span();
    for (int k = 0; k < n; k++) put_sym(flag_pat[8*k +: 8], closing && (k == n - 1));
  endtask

  task automatic put_escape();
    for (int k = 0; k < fes_pkg::EscLen; k++) put_sym(esc_sym(k), 1'b0);
  endtask

  task automatic advance_head();
    logic [7:0] h;
    h = window[0];
    if (pass_left > 0) begin
      put_sym(h, 1'b0);
      pass_left--;
    end else if (flag_at_head()) begin
      put_escape();
      put_sym(h, 1'b0);
      pass_left = (flag_span() - 1) & 7;
    end else if (escape_at_head()) begin
      put_escape();
      put_sym(h, 1'b0);
      pass_left = (fes_pkg::EscLen - 1) & 7;
    end else begin
      put_sym(h, 1'b0);
    end
    for (int k = 0; k < WINDOW_DEPTH - 1; k++) window[k] = window[k+1];
    window[WINDOW_DEPTH-1] = 8'h00;
    held--;
  endtask

  task automatic stuff_word(input logic [1:0] op, input logic [7:0] s);
    word_q.delete();
    unique case (op)
      fes_pkg::OP_START: begin
        clear_window();
        put_flag(1'b0);
      end
      fes_pkg::OP_DATA: begin
        if (held >= WINDOW_DEPTH) advance_head();
        window[held] = s;
        held++;
        if (held == WINDOW_DEPTH) advance_head();
      end
      fes_pkg::OP_DRAIN: begin
        if (held > 0) advance_head();
        if (held == 0) begin
          pass_left = 0;
          put_flag(1'b1);
        end
      end
      default: ;
    endcase
    if (word_q.size() > 0) word_q[word_q.size()-1].last = 1'b1;
    foreach (word_q[i]) stuffed_q.push_back(word_q[i]);
  endtask

  always @(posedge clk) begin
    framed_word_t want;
    if (rst) begin
      flag_len = fes_pkg::FLAG_LEN_RESET;
      flag_pat = fes_pkg::FLAG_PATTERN_RESET;
      clear_window();
      stuffed_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_FLAG_LEN) flag_len = pwdata[3:0];
        else if (paddr == ADDR_FLAG_PATTERN) flag_pat = pwdata;
      end
      if (out_valid && !out_stall) begin
        if (stuffed_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word: expected none, got symbol %h last %b end %b",
                   $time, symbol_out, run_last, frame_end);
        end else begin
          want = stuffed_q.pop_front();
          if (want.sym != symbol_out || want.last != run_last || want.fend != frame_end) begin
            fails++;
            $display("%0t: mismatch: expected symbol %h last %b end %b,",
                     $time, want.sym, want.last, want.fend,
                     " got symbol %h last %b end %b", symbol_out, run_last, frame_end);
          end
        end
      end
      if (in_valid && !in_stall) stuff_word(opcode, symbol_in);
    end
    pending = stuffed_q.size();
  end

endmodule

/* tb/flag_escape_stuffer_tb.sv */
`timescale 1ns / 1ps

module flag_escape_stuffer_tb;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [3:0] ADDR_FLAG_LEN = {fes_pkg::REG_FLAG_LEN, 3'b000};
  localparam logic [3:0] ADDR_FLAG_PATTERN = {fes_pkg::REG_FLAG_PATTERN, 3'b000};
  localparam int CycleLimit = 600000;
  localparam int PhaseWords = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [63:0] pwdata = 64'd0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = fes_pkg::OP_START;
  logic [7:0]  symbol_in = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  symbol_out;
  logic        run_last;
  logic        frame_end;

  int          fails;
  int          pending;
  int          cycles = 0;
  int          stall_left = 0;
  int          sent = 0;
  logic        idle_in = 1'b1;
  logic        idle_out = 1'b1;
  logic [63:0] cur_pattern = fes_pkg::FLAG_PATTERN_RESET;

  always #4 clk = ~clk;

  flag_escape_stuffer uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .symbol_in(symbol_in),
    .out_valid(out_valid), .out_stall(out_stall), .symbol_out(symbol_out),
    .run_last(run_last), .frame_end(frame_end)
  );

  flag_escape_stuffer_checker stuff_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .symbol_in(symbol_in),
    .out_valid(out_valid), .out_stall(out_stall), .symbol_out(symbol_out),
    .run_last(run_last), .frame_end(frame_end),
    .fails(fails), .pending(pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_out && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
    out_stall <= (stall_left > 0);
  end

  task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_word(input logic [1:0] op, input logic [7:0] sym);
    if (idle_in && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    symbol_in <= sym;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_frame();
    logic [7:0] body[$];
    int n;
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 3))
        0: begin
          n = $urandom_range(1, 8);
          for (int k = 0; k < n; k++) body.push_back(cur_pattern[8*k +: 8]);
        end
        1: begin
          n = $urandom_range(1, fes_pkg::EscLen);
          for (int k = 0; k < n; k++)
            body.push_back((k == fes_pkg::EscLen - 1) ? fes_pkg::ESC_TAIL : fes_pkg::ESC_BODY);
        end
        2: repeat ($urandom_range(1, 4))
             body.push_back($urandom_range(0, 1) ? fes_pkg::ESC_BODY : fes_pkg::ESC_TAIL);
        default: repeat ($urandom_range(1, 4)) body.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    send_word(fes_pkg::OP_START, 8'($urandom_range(0, 255)));
    foreach (body[i]) send_word(fes_pkg::OP_DATA, body[i]);
    n = (body.size() < 8) ? body.size() : 8;
    repeat (n) send_word(fes_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) send_word(fes_pkg::OP_DRAIN, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input logic [3:0] len, input logic [63:0] pat, input logic busy);
    int target;
    wait_drained();
    reg_write(ADDR_FLAG_LEN, {60'd0, len});
    reg_write(ADDR_FLAG_PATTERN, pat);
    cur_pattern = pat;
    idle_in = busy;
    idle_out <= busy;
    target = sent + PhaseWords;
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        send_frame();
      end
      if (busy) begin
        idle_in = $urandom_range(0, 3) != 0;
        idle_out <= idle_in;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(fes_pkg::OP_START, 8'h00);
    for (int k = 0; k < 8; k++) send_word(fes_pkg::OP_DATA, cur_pattern[8*k +: 8]);
    for (int k = 0; k < fes_pkg::EscLen; k++)
      send_word(fes_pkg::OP_DATA,
                (k == fes_pkg::EscLen - 1) ? fes_pkg::ESC_TAIL : fes_pkg::ESC_BODY);
    send_word(OP_IGNORED, 8'hFF);
    repeat (8) send_word(fes_pkg::OP_DRAIN, 8'h00);
    send_word(fes_pkg::OP_DRAIN, 8'hFF);
    send_word(fes_pkg::OP_DATA, 8'hFF);
    send_word(fes_pkg::OP_DATA, 8'h00);
    send_word(fes_pkg::OP_START, 8'hFF);

    run_phase(4'd1, {$urandom, $urandom}, 1'b1);
    run_phase(4'd0, 64'h0, 1'b1);
    run_phase(4'd15, {64{1'b1}}, 1'b1);
    run_phase(4'd7, {8{fes_pkg::ESC_BODY}}, 1'b1);
    run_phase(4'd9, {$urandom, $urandom}, 1'b1);
    run_phase(4'd3, {fes_pkg::ESC_BODY, fes_pkg::ESC_TAIL, 8'h00, 8'hFF,
                     8'h30, 8'h31, fes_pkg::ESC_TAIL, fes_pkg::ESC_BODY}, 1'b1);
    run_phase(fes_pkg::FLAG_LEN_RESET, fes_pkg::FLAG_PATTERN_RESET, 1'b0);

    wait_drained();
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
